### src/goa_pkg.sv
// Shared types, constants and the elaboration-time arctangent table builder
// for the gradient orientation block. No dependencies.
package goa_pkg;

  // Table size must be a power of two; the index divider produces its bits.
  localparam int ATAN_TABLE_SIZE = 1024;
  localparam int IDX_W           = $clog2(ATAN_TABLE_SIZE);
  localparam int Q_W             = IDX_W + 1;          // index 0 .. ATAN_TABLE_SIZE
  localparam int DIV_STEPS       = IDX_W + 1;          // one quotient bit per stage
  localparam int MAG_W           = 16;                 // magnitude of a 16-bit input
  localparam int ANG_W           = 13;                 // table angle, at most pi/4
  localparam int ORI_W           = 15;                 // orientation, 0 .. pi

  // Angles in radians times 8192
  localparam logic [ORI_W-1:0] PI_Q13      = 15'd25736;
  localparam logic [ORI_W-1:0] HALF_PI_Q13 = 15'd12868;

  // Quadrant and swap decisions that ride along with each word
  typedef struct packed {
    logic swapped;    // vertical magnitude was strictly larger
    logic same_sign;  // first or third quadrant
    logic zero;       // both magnitudes are zero
  } ctl_t;

  typedef logic [ANG_W-1:0] atan_rom_t [0:ATAN_TABLE_SIZE];

  // Shift-subtract unsigned division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(p / q) in Q31 by alternating power series, for p <= q / 2
  function automatic logic [63:0] series_q31(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] w;
    logic [63:0] sum;
    logic [63:0] term;
    z   = udiv64(p << 31, q);
    z2  = (z * z) >> 31;
    w   = z;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (w != 64'd0) begin
        term = udiv64(w, 64'(2 * k + 1));
        if ((k % 2) == 0) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
        w = (w * z2) >> 31;
      end
    end
    return sum;
  endfunction

  // Round a Q31 angle to Q13
  function automatic logic [ANG_W-1:0] q31_to_q13(input logic [63:0] v);
    logic [63:0] r;
    r = (v + 64'(1 << 17)) >> 18;
    return r[ANG_W-1:0];
  endfunction

  // Build atan(i / N) for i = 0 .. N
  function automatic atan_rom_t build_atan_rom();
    atan_rom_t   rom;
    logic [63:0] quarter;
    logic [63:0] n;
    logic [63:0] v;
    n       = 64'(ATAN_TABLE_SIZE);
    quarter = 64'd4 * series_q31(64'd1, 64'd5) - series_q31(64'd1, 64'd239);
    for (int i = 0; i <= ATAN_TABLE_SIZE; i++) begin
      if (64'(2 * i) <= n) begin
        v = series_q31(64'(i), n);
      end else begin
        v = quarter - series_q31(n - 64'(i), n + 64'(i));
      end
      rom[i] = q31_to_q13(v);
    end
    return rom;
  endfunction

endpackage

### src/goa_fold.sv
// First stage: magnitudes, swap so the smaller sits over the larger, quadrant flags.
// Depends on goa_pkg.
module goa_fold (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [15:0]           grad_x,
  input  logic signed [15:0]           grad_y,
  output logic                         out_valid,
  output logic [goa_pkg::MAG_W-1:0]    lo,
  output logic [goa_pkg::MAG_W-1:0]    hi,
  output goa_pkg::ctl_t                ctl
);

  logic                      x_neg;
  logic                      y_neg;
  logic [goa_pkg::MAG_W-1:0] ax;
  logic [goa_pkg::MAG_W-1:0] ay;
  logic                      swap;

  // Take magnitudes; the most negative input maps to 0x8000 exactly
  always_comb begin
    x_neg = grad_x[15];
    y_neg = grad_y[15];
    ax    = x_neg ? (~grad_x[15:0] + 16'd1) : grad_x[15:0];
    ay    = y_neg ? (~grad_y[15:0] + 16'd1) : grad_y[15:0];
    swap  = (ay > ax);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Hold the folded pair
  always_ff @(posedge clk) begin
    if (en) begin
      lo            <= swap ? ax : ay;
      hi            <= swap ? ay : ax;
      ctl.swapped   <= swap;
      ctl.same_sign <= (x_neg == y_neg);
      ctl.zero      <= (ax == '0) && (ay == '0);
    end
  end

endmodule

### src/goa_div_step.sv
// One restoring-division stage: produces one quotient bit of the table index.
// Depends on goa_pkg.
module goa_div_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [goa_pkg::MAG_W:0]      trial,
  input  logic [goa_pkg::MAG_W-1:0]    hi_in,
  input  logic [goa_pkg::Q_W-1:0]      q_in,
  input  goa_pkg::ctl_t                ctl_in,
  output logic                         out_valid,
  output logic [goa_pkg::MAG_W-1:0]    rem,
  output logic [goa_pkg::MAG_W-1:0]    hi_out,
  output logic [goa_pkg::Q_W-1:0]      q_out,
  output goa_pkg::ctl_t                ctl_out
);

  logic                    fits;
  logic [goa_pkg::MAG_W:0] diff;

  // Compare and subtract the divisor
  always_comb begin
    fits = (trial >= {1'b0, hi_in});
    diff = trial - {1'b0, hi_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Advance remainder and partial quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem     <= fits ? diff[goa_pkg::MAG_W-1:0] : trial[goa_pkg::MAG_W-1:0];
      hi_out  <= hi_in;
      q_out   <= {q_in[goa_pkg::Q_W-2:0], fits};
      ctl_out <= ctl_in;
    end
  end

endmodule

### src/goa_rom.sv
// Registered-read arctangent table, atan(i / N) in Q13 for i = 0 .. N.
// Depends on goa_pkg (table contents are built at elaboration).
module goa_rom (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [goa_pkg::Q_W-1:0]      idx,
  input  goa_pkg::ctl_t                ctl_in,
  output logic                         out_valid,
  output logic [goa_pkg::ANG_W-1:0]    angle,
  output goa_pkg::ctl_t                ctl_out
);

  localparam goa_pkg::atan_rom_t ATAN_ROM = goa_pkg::build_atan_rom();

  logic [goa_pkg::Q_W-1:0] addr;

  // Zero vector reads entry zero
  assign addr = ctl_in.zero ? '0 : idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle   <= ATAN_ROM[addr];
      ctl_out <= ctl_in;
    end
  end

endmodule

### src/gradient_orientation_atan_lut.sv
// Gradient orientation modulo pi, top level.
// Depends on goa_pkg, goa_fold, goa_div_step, goa_rom.
//
// Usage:
//   Input channel (in_valid / in_ready) takes one signed gradient pair
//   grad_x, grad_y per word. Output channel (out_valid / out_ready) gives
//   one orientation per input word, radians times 8192, range 0 .. 25736.
//   Words leave in the order they entered.
// Stages: one fold stage (magnitudes and swap), one stage per index bit
//   of the restoring divider (log2(table size) + 1 stages), one table read
//   stage and one output register holding the quadrant correction.
// Throughput: one word per clock while the output is not stalled; every stage holds one word.
// Stall: when out_valid is high and out_ready low, every stage holds and
//   in_ready drops in the same cycle; nothing is lost or repeated.
// Reset: rst is synchronous, active high, and empties every stage. The
//   arctangent table is constant and needs no fill after reset.
module gradient_orientation_atan_lut (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         grad_x,
  input  logic signed [15:0]         grad_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [goa_pkg::ORI_W-1:0]  orientation
);

  localparam int STEPS = goa_pkg::DIV_STEPS;

  logic                      adv;
  logic                      fold_valid;
  logic [goa_pkg::MAG_W-1:0] fold_lo;
  logic [goa_pkg::MAG_W-1:0] fold_hi;
  goa_pkg::ctl_t             fold_ctl;

  logic                      step_valid [0:STEPS-1];
  logic [goa_pkg::MAG_W-1:0] step_rem   [0:STEPS-1];
  logic [goa_pkg::MAG_W-1:0] step_hi    [0:STEPS-1];
  logic [goa_pkg::Q_W-1:0]   step_q     [0:STEPS-1];
  goa_pkg::ctl_t             step_ctl   [0:STEPS-1];

  logic                      rom_valid;
  logic [goa_pkg::ANG_W-1:0] rom_angle;
  goa_pkg::ctl_t             rom_ctl;
  logic [goa_pkg::ORI_W-1:0] a_ext;
  logic [goa_pkg::ORI_W-1:0] orientation_next;

  // Advance all stages unless the output word is stalled
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  goa_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (in_valid),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .out_valid (fold_valid),
    .lo        (fold_lo),
    .hi        (fold_hi),
    .ctl       (fold_ctl)
  );

  // Divider chain: floor(lo * N / hi), one bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_div
    if (k == 0) begin : g_first
      goa_div_step u_step (
        .clk       (clk),
        .rst       (rst),
        .en        (adv),
        .in_valid  (fold_valid),
        .trial     ({1'b0, fold_lo}),
        .hi_in     (fold_hi),
        .q_in      ('0),
        .ctl_in    (fold_ctl),
        .out_valid (step_valid[k]),
        .rem       (step_rem[k]),
        .hi_out    (step_hi[k]),
        .q_out     (step_q[k]),
        .ctl_out   (step_ctl[k])
      );
    end else begin : g_next
      goa_div_step u_step (
        .clk       (clk),
        .rst       (rst),
        .en        (adv),
        .in_valid  (step_valid[k-1]),
        .trial     ({step_rem[k-1], 1'b0}),
        .hi_in     (step_hi[k-1]),
        .q_in      (step_q[k-1]),
        .ctl_in    (step_ctl[k-1]),
        .out_valid (step_valid[k]),
        .rem       (step_rem[k]),
        .hi_out    (step_hi[k]),
        .q_out     (step_q[k]),
        .ctl_out   (step_ctl[k])
      );
    end
  end

  goa_rom u_rom (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (step_valid[STEPS-1]),
    .idx       (step_q[STEPS-1]),
    .ctl_in    (step_ctl[STEPS-1]),
    .out_valid (rom_valid),
    .angle     (rom_angle),
    .ctl_out   (rom_ctl)
  );

  // Fold the table angle into 0 .. pi by octant and quadrant
  always_comb begin
    a_ext = {{(goa_pkg::ORI_W - goa_pkg::ANG_W){1'b0}}, rom_angle};
    if (rom_ctl.same_sign) begin
      orientation_next = rom_ctl.swapped ? (goa_pkg::HALF_PI_Q13 - a_ext) : a_ext;
    end else begin
      orientation_next = rom_ctl.swapped ? (goa_pkg::HALF_PI_Q13 + a_ext)
                                         : (goa_pkg::PI_Q13 - a_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rom_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      orientation <= orientation_next;
    end
  end

endmodule

### src/goa_check.sv
// Port-level checker for the gradient orientation block, with its bind.
// Depends on goa_pkg and the top level gradient_orientation_atan_lut.
module goa_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic signed [15:0]         grad_x,
  input logic signed [15:0]         grad_y,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [goa_pkg::ORI_W-1:0]  orientation
);

  // Orientation stays within the half turn
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (orientation <= goa_pkg::PI_Q13))
    else $error("orientation above pi");

  // A stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(orientation)))
    else $error("stalled output word changed");

  // A waiting input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(grad_x) && $stable(grad_y)))
    else $error("waiting input word changed");

  // Input is never blocked while the output side is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked with free output");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid after reset");

endmodule

bind gradient_orientation_atan_lut goa_check u_goa_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .grad_x      (grad_x),
  .grad_y      (grad_y),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .orientation (orientation)
);
